// ===== rtl/sacp_pkg.sv =====
package sacp_pkg;

  localparam int unsigned LINE_BYTES_DEF = 32;

  localparam int unsigned ANGLE_MAX = 180;
  localparam logic [7:0] MAG_SAT = 8'd181;
  localparam logic [9:0] COMPARE_RESET = 10'd375;
  localparam logic [9:0] COMPARE_BASE = 10'd125;

  // angle * 500 / 180 is angle * 25 / 9; 25 * round(2^16 / 9) gives an exact floor up to 180.
  localparam logic [17:0] COMPARE_RECIP = 18'd182050;
  localparam int unsigned COMPARE_SHIFT = 16;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SIGN = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL = 3'd3,
    PH_NUM_END = 3'd4,
    PH_BAD = 3'd5,
    PH_EMPTY_END = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic [7:0] angle;
    logic [9:0] compare_value;
  } result_t;

  function automatic logic [9:0] compare_of(input logic [7:0] ang);
    logic [25:0] prod;
    begin
      prod = 26'(ang) * 26'(COMPARE_RECIP);
      return COMPARE_BASE + 10'(prod >> COMPARE_SHIFT);
    end
  endfunction

endpackage

// ===== rtl/sacp_in_stage.sv =====
module sacp_in_stage
  import sacp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic held_valid_next;

  assign in_ready = !held_valid || advance;

  always_comb begin
    held_valid_next = held_valid;
    if (in_ready) begin
      held_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== rtl/sacp_parser.sv =====
module sacp_parser
  import sacp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_char,
  output logic       line_end,
  output result_t    result
);

  localparam int unsigned CNT_W = $clog2(LINE_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BYTES - 1);

  logic [CNT_W-1:0] line_count, line_count_next;
  phase_t           parse_phase, parse_phase_next;
  logic             negative_sign, negative_sign_next;
  logic [7:0]       magnitude, magnitude_next;
  logic             non_blank_seen, non_blank_seen_next;
  logic [9:0]       held_compare, held_compare_next;

  logic       is_crlf, is_digit, is_blank, is_vf;
  logic [3:0] digit;
  logic [11:0] mag_acc;
  status_t    line_status;
  logic [7:0] line_angle;

  assign is_crlf  = (rx_char == CH_CR) || (rx_char == CH_LF);
  assign is_digit = (rx_char >= CH_ZERO) && (rx_char <= CH_NINE);
  assign is_blank = (rx_char == CH_SPACE) || (rx_char == CH_TAB);
  assign is_vf    = (rx_char == CH_VT) || (rx_char == CH_FF);
  assign digit    = 4'(rx_char - CH_ZERO);
  assign mag_acc  = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} + 12'(digit);

  assign line_end = is_crlf && (line_count != '0);

  always_comb begin
    line_status = ST_INVALID;
    line_angle  = 8'd0;
    case (parse_phase)
      PH_LEAD: begin
        line_status = non_blank_seen ? ST_INVALID : ST_EMPTY;
      end
      PH_EMPTY_END: begin
        line_status = ST_EMPTY;
      end
      PH_DIGITS, PH_TRAIL, PH_NUM_END: begin
        if ((magnitude > 8'(ANGLE_MAX)) || (negative_sign && (magnitude != 8'd0))) begin
          line_status = ST_INVALID;
        end else begin
          line_status = ST_OK;
          line_angle  = magnitude;
        end
      end
      default: begin
        line_status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    result.status        = line_status;
    result.angle         = line_angle;
    result.compare_value = (line_status == ST_OK) ? compare_of(line_angle) : held_compare;
  end

  always_comb begin
    line_count_next     = line_count;
    parse_phase_next    = parse_phase;
    negative_sign_next  = negative_sign;
    magnitude_next      = magnitude;
    non_blank_seen_next = non_blank_seen;
    held_compare_next   = held_compare;
    if (step) begin
      if (!is_crlf) begin
        if (line_count < CNT_MAX) begin
          line_count_next = line_count + 1'b1;
          case (parse_phase)
            PH_LEAD: begin
              if (rx_char == CH_NUL) begin
                parse_phase_next = non_blank_seen ? PH_BAD : PH_EMPTY_END;
              end else if (is_blank) begin
                parse_phase_next = PH_LEAD;
              end else if (is_vf) begin
                non_blank_seen_next = 1'b1;
              end else begin
                non_blank_seen_next = 1'b1;
                if ((rx_char == CH_PLUS) || (rx_char == CH_MINUS)) begin
                  negative_sign_next = (rx_char == CH_MINUS);
                  parse_phase_next   = PH_SIGN;
                end else if (is_digit) begin
                  magnitude_next   = 8'(digit);
                  parse_phase_next = PH_DIGITS;
                end else begin
                  parse_phase_next = PH_BAD;
                end
              end
            end
            PH_SIGN: begin
              if (is_digit) begin
                magnitude_next   = 8'(digit);
                parse_phase_next = PH_DIGITS;
              end else begin
                parse_phase_next = PH_BAD;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                magnitude_next = (mag_acc > 12'(ANGLE_MAX)) ? MAG_SAT : mag_acc[7:0];
              end else if (is_blank) begin
                parse_phase_next = PH_TRAIL;
              end else if (rx_char == CH_NUL) begin
                parse_phase_next = PH_NUM_END;
              end else begin
                parse_phase_next = PH_BAD;
              end
            end
            PH_TRAIL: begin
              if (rx_char == CH_NUL) begin
                parse_phase_next = PH_NUM_END;
              end else if (!is_blank) begin
                parse_phase_next = PH_BAD;
              end
            end
            PH_NUM_END, PH_BAD, PH_EMPTY_END: begin
              parse_phase_next = parse_phase;
            end
            default: begin
              parse_phase_next = PH_BAD;
            end
          endcase
        end
      end else if (line_count != '0) begin
        held_compare_next   = result.compare_value;
        line_count_next     = '0;
        parse_phase_next    = PH_LEAD;
        negative_sign_next  = 1'b0;
        magnitude_next      = 8'd0;
        non_blank_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= '0;
      parse_phase    <= PH_LEAD;
      negative_sign  <= 1'b0;
      magnitude      <= 8'd0;
      non_blank_seen <= 1'b0;
      held_compare   <= COMPARE_RESET;
    end else begin
      line_count     <= line_count_next;
      parse_phase    <= parse_phase_next;
      negative_sign  <= negative_sign_next;
      magnitude      <= magnitude_next;
      non_blank_seen <= non_blank_seen_next;
      held_compare   <= held_compare_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    line_count <= CNT_MAX)
    else $error("Line length count beyond the stored limit.");

  a_mag_bounded: assert property (@(posedge clk) disable iff (rst)
    magnitude <= MAG_SAT)
    else $error("Magnitude beyond the saturation value.");

  a_compare_held: assert property (@(posedge clk) disable iff (rst)
    !(step && line_end && (line_status == ST_OK)) |=> $stable(held_compare))
    else $error("Compare value changed without a valid line.");

endmodule

// ===== rtl/sacp_out_stage.sv =====
module sacp_out_stage
  import sacp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_free,
  output result_t result_out
);

  logic out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== rtl/servo_angle_command_parser.sv =====
// Servo angle command parser. Received characters arrive on the input channel
// (in_valid, in_ready, rx_byte), one per transfer. A carriage return or line feed
// closes a non-empty line, which produces one result transfer on the output
// channel (out_valid, out_ready, status, angle, compare_value); a line end with
// nothing before it and every other character produce none.
// A character goes into an input register and is parsed from there; a line's
// result is registered in the output register when its line end is taken from it.
// One character can be taken in every cycle; the per-character parse update and
// the line-end decision each fit between the input register and the result
// register, and the compare value comes from one constant multiplication.
// While a result waits on out_ready, further characters are still taken unless
// the held character would itself close a line; then in_ready falls until the
// waiting result is transferred.
// Reset empties both registers, clears the line state and sets the compare value
// to 375, the setting for 90 degrees.
module servo_angle_command_parser
  import sacp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] angle,
  output logic [9:0] compare_value
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       line_end;
  logic       out_free;
  logic       advance;
  result_t    line_result;
  result_t    out_result;

  assign advance = held_valid && (!line_end || out_free);

  sacp_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .advance   (advance),
    .held_valid(held_valid),
    .held_byte (held_byte)
  );

  sacp_parser #(
    .LINE_BYTES(LINE_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_char (held_byte),
    .line_end(line_end),
    .result  (line_result)
  );

  sacp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && line_end),
    .result_in (line_result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_free  (out_free),
    .result_out(out_result)
  );

  assign status        = out_result.status;
  assign angle         = out_result.angle;
  assign compare_value = out_result.compare_value;

  a_angle_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result.status == ST_OK)) |-> (angle <= 8'(ANGLE_MAX)))
    else $error("Accepted angle above the servo range.");

  a_angle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result.status != ST_OK)) |-> (angle == 8'd0))
    else $error("Angle not zero on a rejected line.");

  a_compare_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((compare_value >= COMPARE_BASE) && (compare_value <= 10'd625)))
    else $error("Compare value outside the pulse range.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(advance && line_end))
    else $error("Waiting result overwritten.");

endmodule
